### sv/ptphr_pkg.sv
`timescale 1ns / 1ps

package ptphr_pkg;

	// Operation carried on the slave-side tuser.
	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_RESET  = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_POINTS_IN_USE   = 2'd0;
	localparam logic [1:0] REG_RECORD_INTERVAL = 2'd1;
	localparam logic [1:0] REG_MIN_CHANGE      = 2'd2;

	// Register reset values.
	localparam logic [5:0]  POINTS_IN_USE_RST   = 6'd32;
	localparam logic [31:0] RECORD_INTERVAL_RST = 32'd10000;
	localparam logic [19:0] MIN_CHANGE_RST      = 20'd500;

	// Stream widths, padded to whole bytes.
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 112;
	localparam int IN_PAD_W   = 6;
	localparam int OUT_PAD_W  = 4;

	// Coordinate difference width: holds the difference of two 32-bit signed values.
	localparam int DIFF_W = 34;

endpackage

### sv/per_track_position_history_ring.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tuser: opcode; tdata: track, lat, lon, now, pos
// m_*       out        m_tvalid / m_tready  tdata: stored, slot, count, read_valid, lat, lon, time
// cfg_*     in         cfg_we               cfg_index, cfg_data
//
// One item is handled at a time. Reset track, unused opcode and out-of-range tracks end
// after the track-state read, read after the point read; record goes on from the point read
// to a coordinate difference step, then the compare and the write-back of both memories.
// After reset, and after every write of points_in_use, a clearing pass walks every entry of
// the track-state memory while s_tready stays low. While a result waits for m_tready, the
// next item may be accepted and holds in its last stage until the output register is free.
module per_track_position_history_ring
	import ptphr_pkg::*;
#(
	parameter int TRACKS = 64,
	parameter int POINTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            s_tuser,  // opcode
	// track_number[5:0], latitude_in[36:6], longitude_in[68:37], now_ms[100:69],
	// logical_position[105:101], zeros above
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// stored[0], slot_written[5:1], point_count[11:6], read_valid[12], latitude_out[43:13],
	// longitude_out[75:44], time_out[107:76], zeros above
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	localparam int TW   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int SW   = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int CW   = $clog2(POINTS + 1);
	localparam int SUMW = ((CW > 5) ? CW : 5) + 1;
	localparam int PD   = TRACKS * POINTS;
	localparam int AW   = (PD > 1) ? $clog2(PD) : 1;
	localparam int TSW  = 32 + SW + CW;
	localparam int PW   = 31 + 32 + 32;

	typedef enum logic [1:0] {S_IDLE, S_TRK, S_PT, S_WR} state_t;

	state_t state_q;

	logic          clr_active_q;
	logic [TW-1:0] clr_idx_q;
	logic [5:0]    pin_q;
	logic [31:0]   interval_q;
	logic [19:0]   min_chg_q;

	op_t                 op_q;
	logic                trk_ok_q;
	logic [TW-1:0]       trk_q;
	logic signed [30:0]  lat_q;
	logic signed [31:0]  lon_q;
	logic [31:0]         now_q;
	logic [4:0]          pos_q;

	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       new_cnt_q;
	logic [SW-1:0]       new_slot_q;
	logic [SW-1:0]       new_head_q;
	logic                early_q;
	logic                have_q;
	logic                rd_ok_q;

	logic signed [DIFF_W-1:0] dlat_p_q, dlat_n_q, dlon_p_q, dlon_n_q;

	logic        m_tvalid_q;
	logic        out_stored_q;
	logic [4:0]  out_slot_q;
	logic [5:0]  out_count_q;
	logic        out_rvalid_q;
	logic [30:0] out_lat_q;
	logic [31:0] out_lon_q;
	logic [31:0] out_time_q;

	// Input fields.
	logic [5:0]  in_track;
	logic [30:0] in_lat;
	logic [31:0] in_lon;
	logic [31:0] in_now;
	logic [4:0]  in_pos;

	// Memory ports.
	logic           trk_we;
	logic [TW-1:0]  trk_waddr;
	logic [TSW-1:0] trk_wdata;
	logic [TW-1:0]  trk_raddr;
	logic [TSW-1:0] trk_rdata;
	logic           pt_we;
	logic [AW-1:0]  pt_waddr;
	logic [PW-1:0]  pt_wdata;
	logic [AW-1:0]  pt_raddr;
	logic [PW-1:0]  pt_rdata;

	logic [CW-1:0] trk_cnt;
	logic [SW-1:0] trk_head;
	logic [31:0]   trk_last;
	logic [CW-1:0] ring_len;
	logic [SW-1:0] slot_last, slot_app, slot_rd, slot_old, head_next;
	logic          full;
	logic [AW-1:0] trk_base;
	logic [30:0]   pt_lat;
	logic [31:0]   pt_lon;
	logic [31:0]   pt_time;
	logic signed [DIFF_W-1:0] a_lat, b_lat, a_lon, b_lon;
	logic [DIFF_W-1:0] abs_lat, abs_lon;
	logic          near;
	logic          take;
	logic          out_free;
	logic          accept;

	function automatic logic [SW-1:0] wrap_slot(input logic [SUMW-1:0] head,
			input logic [SUMW-1:0] idx, input logic [CW-1:0] len);
		logic [SUMW-1:0] s;
		s = head + idx;
		if (s >= SUMW'(len)) begin
			s = s - SUMW'(len);
		end
		if (s >= SUMW'(POINTS)) begin
			s = '0;
		end
		return s[SW-1:0];
	endfunction

	assign in_track = s_tdata[5:0];
	assign in_lat   = s_tdata[36:6];
	assign in_lon   = s_tdata[68:37];
	assign in_now   = s_tdata[100:69];
	assign in_pos   = s_tdata[105:101];

	assign s_tready = (state_q == S_IDLE) && !clr_active_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign trk_cnt  = trk_rdata[CW-1:0];
	assign trk_head = trk_rdata[CW +: SW];
	assign trk_last = trk_rdata[CW+SW +: 32];

	assign pt_lat  = pt_rdata[30:0];
	assign pt_lon  = pt_rdata[62:31];
	assign pt_time = pt_rdata[94:63];

	always_comb begin
		if (pin_q == 6'd0) begin
			ring_len = CW'(1);
		end else if (32'(pin_q) > 32'(POINTS)) begin
			ring_len = CW'(POINTS);
		end else begin
			ring_len = CW'(pin_q);
		end
	end

	always_comb begin
		slot_last = wrap_slot(SUMW'(trk_head), SUMW'(CW'(trk_cnt - 1'b1)), ring_len);
		slot_app  = wrap_slot(SUMW'(trk_head), SUMW'(trk_cnt), ring_len);
		slot_rd   = wrap_slot(SUMW'(trk_head), SUMW'(pos_q), ring_len);
		slot_old  = wrap_slot(SUMW'(trk_head), '0, ring_len);
		head_next = wrap_slot(SUMW'(slot_old), SUMW'(1), ring_len);
		full      = trk_cnt >= ring_len;
		trk_base  = AW'(trk_q) * AW'(POINTS);
	end

	// The point read address is formed from the registered track state read data; the track
	// address is held while busy, so both read data words stay stable during a stall.
	assign trk_raddr = (state_q == S_IDLE) ? TW'(in_track) : trk_q;
	assign pt_raddr  = trk_base + AW'((op_q == OP_READ) ? slot_rd : slot_last);

	always_comb begin
		a_lat   = DIFF_W'(lat_q);
		b_lat   = DIFF_W'($signed(pt_lat));
		a_lon   = DIFF_W'(lon_q);
		b_lon   = DIFF_W'($signed(pt_lon));
		abs_lat = dlat_p_q[DIFF_W-1] ? dlat_n_q : dlat_p_q;
		abs_lon = dlon_p_q[DIFF_W-1] ? dlon_n_q : dlon_p_q;
		near    = (abs_lat < DIFF_W'(min_chg_q)) && (abs_lon < DIFF_W'(min_chg_q));
		take    = !have_q || !(early_q || near);
	end

	always_comb begin
		trk_we    = 1'b0;
		trk_waddr = trk_q;
		trk_wdata = '0;
		pt_we     = 1'b0;
		pt_waddr  = trk_base + AW'(new_slot_q);
		pt_wdata  = {now_q, lon_q, lat_q};
		if (clr_active_q) begin
			trk_we    = 1'b1;
			trk_waddr = clr_idx_q;
		end else if (state_q == S_TRK && op_q == OP_RESET && trk_ok_q && out_free) begin
			trk_we = 1'b1;
		end else if (state_q == S_WR && out_free && take) begin
			trk_we    = 1'b1;
			trk_wdata = {now_q, new_head_q, new_cnt_q};
			pt_we     = 1'b1;
		end
	end

	ptphr_ram #(
		.WIDTH(TSW),
		.DEPTH(TRACKS)
	) u_track_ram (
		.clk  (clk),
		.we   (trk_we),
		.waddr(trk_waddr),
		.wdata(trk_wdata),
		.raddr(trk_raddr),
		.rdata(trk_rdata)
	);

	ptphr_ram #(
		.WIDTH(PW),
		.DEPTH(PD)
	) u_point_ram (
		.clk  (clk),
		.we   (pt_we),
		.waddr(pt_waddr),
		.wdata(pt_wdata),
		.raddr(pt_raddr),
		.rdata(pt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
			pin_q        <= POINTS_IN_USE_RST;
			interval_q   <= RECORD_INTERVAL_RST;
			min_chg_q    <= MIN_CHANGE_RST;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (clr_active_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (32'(clr_idx_q) == TRACKS - 1) begin
					clr_active_q <= 1'b0;
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_POINTS_IN_USE: begin
						pin_q        <= cfg_data[5:0];
						clr_active_q <= 1'b1;
						clr_idx_q    <= '0;
					end
					REG_RECORD_INTERVAL: interval_q <= cfg_data;
					REG_MIN_CHANGE:      min_chg_q  <= cfg_data[19:0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= op_t'(s_tuser);
						trk_ok_q <= 32'(in_track) < 32'(TRACKS);
						trk_q    <= TW'(in_track);
						lat_q    <= in_lat;
						lon_q    <= in_lon;
						now_q    <= in_now;
						pos_q    <= in_pos;
						state_q  <= S_TRK;
					end
				end
				S_TRK: begin
					cnt_q   <= trk_cnt;
					early_q <= (now_q - trk_last) < interval_q;
					have_q  <= trk_cnt != '0;
					rd_ok_q <= SUMW'(pos_q) < SUMW'(trk_cnt);
					if (full) begin
						new_slot_q <= slot_old;
						new_head_q <= head_next;
						new_cnt_q  <= trk_cnt;
					end else begin
						new_slot_q <= slot_app;
						new_head_q <= trk_head;
						new_cnt_q  <= trk_cnt + 1'b1;
					end
					if (trk_ok_q && (op_q == OP_RECORD || op_q == OP_READ)) begin
						state_q <= S_PT;
					end else if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_stored_q <= 1'b0;
						out_slot_q   <= '0;
						out_rvalid_q <= 1'b0;
						out_lat_q    <= '0;
						out_lon_q    <= '0;
						out_time_q   <= '0;
						out_count_q  <= (trk_ok_q && op_q == OP_NONE) ? 6'(trk_cnt) : '0;
						state_q      <= S_IDLE;
					end
				end
				S_PT: begin
					dlat_p_q <= a_lat - b_lat;
					dlat_n_q <= b_lat - a_lat;
					dlon_p_q <= a_lon - b_lon;
					dlon_n_q <= b_lon - a_lon;
					if (op_q == OP_RECORD) begin
						state_q <= S_WR;
					end else if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_stored_q <= 1'b0;
						out_slot_q   <= '0;
						out_count_q  <= 6'(cnt_q);
						out_rvalid_q <= rd_ok_q;
						out_lat_q    <= rd_ok_q ? pt_lat : '0;
						out_lon_q    <= rd_ok_q ? pt_lon : '0;
						out_time_q   <= rd_ok_q ? pt_time : '0;
						state_q      <= S_IDLE;
					end
				end
				S_WR: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_stored_q <= take;
						out_slot_q   <= take ? 5'(new_slot_q) : '0;
						out_count_q  <= take ? 6'(new_cnt_q) : 6'(cnt_q);
						out_rvalid_q <= 1'b0;
						out_lat_q    <= '0;
						out_lon_q    <= '0;
						out_time_q   <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_time_q, out_lon_q, out_lat_q, out_rvalid_q,
		out_count_q, out_slot_q, out_stored_q};

	// No item may enter while the track state is being cleared.
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !s_tready)
		else $error("item accepted during track clearing pass");

	// A track never holds more points than the ring in use.
	a_count_fits_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRK && trk_ok_q) |-> (trk_cnt <= ring_len))
		else $error("track fill count exceeds ring length");

	// The oldest-point pointer always names a built slot.
	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRK && trk_ok_q) |-> (32'(trk_head) < 32'(POINTS)))
		else $error("track head beyond built depth");

	// A new result is only loaded when the output register is free.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> $stable(m_tdata))
		else $error("pending result overwritten");

endmodule

### sv/ptphr_ram.sv
`timescale 1ns / 1ps

module ptphr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
